FILE: hdl/sds_pkg.sv
// shared types and constants for the scan disk scheduler
package sds_pkg;

    localparam int SDS_MAX_REQUESTS  = 32;
    localparam int SDS_CYLINDER_BITS = 16;
    localparam int SDS_QUEUE_DEPTH   = 2;

    localparam int SDS_MAX_CYL_RESET    = 199;
    localparam int SDS_DIR_UP_RESET     = 1;
    localparam int SDS_START_HEAD_RESET = 0;

    typedef logic [1:0] sds_cfg_idx_t;

    localparam sds_cfg_idx_t CFG_MAX_CYLINDER = 2'd0;
    localparam sds_cfg_idx_t CFG_DIRECTION_UP = 2'd1;
    localparam sds_cfg_idx_t CFG_START_HEAD   = 2'd2;

    // classification of an accepted request
    typedef struct packed {
        logic store;
        logic last;
    } sds_kind_t;

    localparam int SDS_KIND_BITS = $bits(sds_kind_t);

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SEARCH,
        ST_FIRST,
        ST_END,
        ST_SECOND
    } sds_state_t;

endpackage

FILE: hdl/sds_front.sv
// front end: accepts requests and classifies them as stored or dropped
module sds_front #(
    parameter int MAX_REQUESTS  = sds_pkg::SDS_MAX_REQUESTS,
    parameter int CYLINDER_BITS = sds_pkg::SDS_CYLINDER_BITS
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [CYLINDER_BITS-1:0]  cylinder,
    input  logic                      last_request,
    input  logic                      q_full,
    output logic                      q_push,
    output sds_pkg::sds_kind_t        q_kind,
    output logic [CYLINDER_BITS-1:0]  q_cyl
);
    import sds_pkg::*;

    localparam int CW = $clog2(MAX_REQUESTS + 1);

    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;
    logic          accept;
    logic          has_room;

    assign busy     = q_full;
    assign accept   = start && !busy;
    assign has_room = (cnt_reg < CW'(MAX_REQUESTS));

    assign q_push       = accept;
    assign q_kind.store = has_room;
    assign q_kind.last  = last_request;
    assign q_cyl        = cylinder;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (accept)
        begin
            if (last_request)
                cnt_next = '0;
            else if (has_room)
                cnt_next = cnt_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

endmodule

FILE: hdl/sds_queue.sv
// short queue between the front and back ends
module sds_queue #(
    parameter int WIDTH = sds_pkg::SDS_CYLINDER_BITS + sds_pkg::SDS_KIND_BITS
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             not_empty,
    output logic             full
);
    import sds_pkg::*;

    localparam int DEPTH = SDS_QUEUE_DEPTH;
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slots_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    cnt_reg;
    logic             do_push;
    logic             do_pop;

    assign full      = (cnt_reg == CW'(DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_data  = slots_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            slots_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            if (do_push && !do_pop)
                cnt_reg <= cnt_reg + CW'(1);
            else if (do_pop && !do_push)
                cnt_reg <= cnt_reg - CW'(1);
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !(do_push && !do_pop))
        else $error("queue written while full");

endmodule

FILE: hdl/sds_back.sv
// back end: sorted insertion of requests and the scan emission walk
module sds_back #(
    parameter int MAX_REQUESTS  = sds_pkg::SDS_MAX_REQUESTS,
    parameter int CYLINDER_BITS = sds_pkg::SDS_CYLINDER_BITS
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      q_not_empty,
    input  sds_pkg::sds_kind_t        q_kind,
    input  logic [CYLINDER_BITS-1:0]  q_cyl,
    output logic                      q_pop,
    input  logic [CYLINDER_BITS-1:0]  max_cylinder,
    input  logic                      direction_up,
    input  logic [CYLINDER_BITS-1:0]  start_head,
    output logic                      result_valid,
    output logic [CYLINDER_BITS-1:0]  visit_cylinder,
    output logic                      is_disk_end,
    output logic [CYLINDER_BITS:0]    total_movement,
    output logic                      last_result
);
    import sds_pkg::*;

    localparam int CB = CYLINDER_BITS;
    localparam int MB = CYLINDER_BITS + 1;
    localparam int CW = $clog2(MAX_REQUESTS + 1);
    localparam int IW = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;

    sds_state_t     state_reg, state_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic [CW-1:0]  idx_reg, idx_next;
    logic [CW-1:0]  below_reg, below_next;
    logic [CB-1:0]  head_reg, head_next;
    logic [MB-1:0]  sum_reg, sum_next;

    logic [CB-1:0]  cells_reg [MAX_REQUESTS];
    logic [MAX_REQUESTS-1:0] keep;
    logic           ins_en;

    logic [CB-1:0]  rd_raw;
    logic [CB-1:0]  rd_val;
    logic [CB-1:0]  emit_cyl;
    logic [CB-1:0]  diff;
    logic [MB:0]    sum_wide;
    logic [MB-1:0]  sum_sat;
    logic           emit;
    logic           emit_end;
    logic           emit_last;
    logic [CW-1:0]  idx_inc;
    logic [CW-1:0]  idx_dec;
    logic           at_top;

    // sorted cells, kept in ascending raw order; clamping is applied on read
    always_comb
    begin
        for (int j = 0; j < MAX_REQUESTS; j++)
            keep[j] = (CW'(j) < cnt_reg) && (cells_reg[j] <= q_cyl);
    end

    always_ff @(posedge clk)
    begin
        if (ins_en)
        begin
            for (int j = 0; j < MAX_REQUESTS; j++)
            begin
                if (!keep[j])
                begin
                    if (j == 0)
                        cells_reg[j] <= q_cyl;
                    else if (keep[j-1])
                        cells_reg[j] <= q_cyl;
                    else
                        cells_reg[j] <= cells_reg[j-1];
                end
            end
        end
    end

    assign rd_raw   = cells_reg[idx_reg[IW-1:0]];
    assign rd_val   = (rd_raw > max_cylinder) ? max_cylinder : rd_raw;
    assign emit_cyl = (state_reg == ST_END) ? (direction_up ? max_cylinder : '0) : rd_val;
    assign diff     = (emit_cyl >= head_reg) ? emit_cyl - head_reg : head_reg - emit_cyl;
    assign sum_wide = {1'b0, sum_reg} + {{(MB + 1 - CB){1'b0}}, diff};
    assign sum_sat  = sum_wide[MB] ? {MB{1'b1}} : sum_wide[MB-1:0];
    assign idx_inc  = idx_reg + CW'(1);
    assign idx_dec  = idx_reg - CW'(1);
    assign at_top   = (idx_inc == cnt_reg);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        below_next = below_reg;
        head_next  = head_reg;
        sum_next   = sum_reg;
        q_pop      = 1'b0;
        ins_en     = 1'b0;
        emit       = 1'b0;
        emit_end   = 1'b0;
        emit_last  = 1'b0;
        unique case (state_reg)
            ST_LOAD:
            begin
                q_pop = q_not_empty;
                if (q_not_empty)
                begin
                    if (q_kind.store)
                    begin
                        ins_en   = 1'b1;
                        cnt_next = cnt_reg + CW'(1);
                    end
                    if (q_kind.last)
                    begin
                        state_next = ST_SEARCH;
                        idx_next   = '0;
                        head_next  = start_head;
                        sum_next   = '0;
                    end
                end
            end
            ST_SEARCH:
            begin
                // count requests lying below the head
                if ((idx_reg < cnt_reg) && (rd_val < head_reg))
                    idx_next = idx_inc;
                else
                begin
                    below_next = idx_reg;
                    if (direction_up)
                        state_next = (idx_reg != cnt_reg) ? ST_FIRST : ST_END;
                    else
                    begin
                        state_next = (idx_reg != '0) ? ST_FIRST : ST_END;
                        idx_next   = idx_dec;
                    end
                end
            end
            ST_FIRST:
            begin
                emit      = 1'b1;
                head_next = emit_cyl;
                sum_next  = sum_sat;
                if (direction_up)
                begin
                    if (at_top)
                        state_next = ST_END;
                    else
                        idx_next = idx_inc;
                end
                else
                begin
                    if (idx_reg == '0)
                        state_next = ST_END;
                    else
                        idx_next = idx_dec;
                end
            end
            ST_END:
            begin
                emit      = 1'b1;
                emit_end  = 1'b1;
                head_next = emit_cyl;
                sum_next  = sum_sat;
                emit_last = direction_up ? (below_reg == '0) : (below_reg == cnt_reg);
                if (emit_last)
                begin
                    state_next = ST_LOAD;
                    cnt_next   = '0;
                end
                else
                begin
                    state_next = ST_SECOND;
                    idx_next   = direction_up ? below_reg - CW'(1) : below_reg;
                end
            end
            ST_SECOND:
            begin
                emit      = 1'b1;
                head_next = emit_cyl;
                sum_next  = sum_sat;
                emit_last = direction_up ? (idx_reg == '0) : at_top;
                if (emit_last)
                begin
                    state_next = ST_LOAD;
                    cnt_next   = '0;
                end
                else
                    idx_next = direction_up ? idx_dec : idx_inc;
            end
            default:
            begin
                state_next = ST_LOAD;
                cnt_next   = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_LOAD;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg      <= '0;
            result_valid <= 1'b0;
        end
        else
        begin
            cnt_reg      <= cnt_next;
            result_valid <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        below_reg <= below_next;
        head_reg  <= head_next;
        sum_reg   <= sum_next;
        if (emit)
        begin
            visit_cylinder <= emit_cyl;
            is_disk_end    <= emit_end;
            last_result    <= emit_last;
            total_movement <= emit_last ? sum_sat : '0;
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(MAX_REQUESTS))
        else $error("request count beyond capacity");

    a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && last_result) |=> !result_valid)
        else $error("beat right after the final beat of a batch");

    a_total_only_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !last_result) |-> (total_movement == '0))
        else $error("movement total on a non-final beat");

    a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_LOAD) |-> !q_pop)
        else $error("queue popped during scheduling");

endmodule

FILE: hdl/scan_disk_scheduler_core.sv
// top level of the scan disk scheduler
// Requests enter one per cycle on start while busy is low; they are sorted into
// place as they arrive. A request marked last starts the schedule: once it has
// passed through the queue, the back end walks the sorted cells to place the head
// among n requests, then emits one result per cycle for the n requests and the
// disk-end visit; each result leaves through an output register. A two-entry queue
// lets the next batch's first requests in while results go out; busy rises when it
// fills. Results are single-cycle strobes on result_valid and cannot be stalled.
// There is no clearing pass after reset.
module scan_disk_scheduler_core #(
    parameter int MAX_REQUESTS  = sds_pkg::SDS_MAX_REQUESTS,
    parameter int CYLINDER_BITS = sds_pkg::SDS_CYLINDER_BITS
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [CYLINDER_BITS-1:0]  cylinder,
    input  logic                      last_request,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  sds_pkg::sds_cfg_idx_t     cfg_index,
    input  logic [CYLINDER_BITS-1:0]  cfg_data,
    output logic                      result_valid,
    output logic [CYLINDER_BITS-1:0]  visit_cylinder,
    output logic                      is_disk_end,
    output logic [CYLINDER_BITS:0]    total_movement,
    output logic                      last_result
);
    import sds_pkg::*;

    localparam int QW = CYLINDER_BITS + SDS_KIND_BITS;

    logic [CYLINDER_BITS-1:0] max_cyl_reg;
    logic                     dir_up_reg;
    logic [CYLINDER_BITS-1:0] start_head_reg;

    logic                     q_full;
    logic                     q_push;
    sds_kind_t                push_kind;
    logic [CYLINDER_BITS-1:0] push_cyl;
    logic                     q_pop;
    logic                     q_not_empty;
    logic [QW-1:0]            q_rd;
    sds_kind_t                pop_kind;
    logic [CYLINDER_BITS-1:0] pop_cyl;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_cyl_reg    <= CYLINDER_BITS'(SDS_MAX_CYL_RESET);
            dir_up_reg     <= 1'(SDS_DIR_UP_RESET);
            start_head_reg <= CYLINDER_BITS'(SDS_START_HEAD_RESET);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_MAX_CYLINDER: max_cyl_reg    <= cfg_data;
                CFG_DIRECTION_UP: dir_up_reg     <= cfg_data[0];
                CFG_START_HEAD:   start_head_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    sds_front #(
        .MAX_REQUESTS  (MAX_REQUESTS),
        .CYLINDER_BITS (CYLINDER_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cylinder     (cylinder),
        .last_request (last_request),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_kind       (push_kind),
        .q_cyl        (push_cyl)
    );

    sds_queue #(
        .WIDTH (QW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data ({push_kind, push_cyl}),
        .pop       (q_pop),
        .pop_data  (q_rd),
        .not_empty (q_not_empty),
        .full      (q_full)
    );

    assign pop_kind = q_rd[QW-1:CYLINDER_BITS];
    assign pop_cyl  = q_rd[CYLINDER_BITS-1:0];

    sds_back #(
        .MAX_REQUESTS  (MAX_REQUESTS),
        .CYLINDER_BITS (CYLINDER_BITS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_not_empty    (q_not_empty),
        .q_kind         (pop_kind),
        .q_cyl          (pop_cyl),
        .q_pop          (q_pop),
        .max_cylinder   (max_cyl_reg),
        .direction_up   (dir_up_reg),
        .start_head     (start_head_reg),
        .result_valid   (result_valid),
        .visit_cylinder (visit_cylinder),
        .is_disk_end    (is_disk_end),
        .total_movement (total_movement),
        .last_result    (last_result)
    );

endmodule
